@@ hdl/object_record_stream_parser_defines.svh @@
// Assertion macros used by the checker of the object record stream parser.
// Depends on nothing; the using module must have i_clk and i_rst_n in scope.
`ifndef OBJECT_RECORD_STREAM_PARSER_DEFINES_SVH
`define OBJECT_RECORD_STREAM_PARSER_DEFINES_SVH

// Condition and consequence in the same cycle, checked outside reset.
`define ORSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition, checked outside reset.
`define ORSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition, also checked across reset.
`define ORSP_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/orsp_pkg.sv @@
// Shared types and constants of the object record stream parser.
// Depends on nothing; used by the front parser, the result queue, the top level and the checker.
package orsp_pkg;

    localparam int ORSP_QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_CODE  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]  rec_kind;
        logic [15:0] target_address;
        logic [15:0] payload;
        logic        record_last;
    } t_item;

endpackage

@@ hdl/orsp_front.sv @@
// Front part of the object record stream parser: header parsing and body item assembly.
// Depends on orsp_pkg; produces at most one result item for each accepted byte.
module orsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    output logic          o_item_valid,
    output orsp_pkg::t_item o_item
);
    import orsp_pkg::*;

    localparam logic [2:0] PH_TAG_HI  = 3'd0;
    localparam logic [2:0] PH_TAG_LO  = 3'd1;
    localparam logic [2:0] PH_ADDR_HI = 3'd2;
    localparam logic [2:0] PH_ADDR_LO = 3'd3;
    localparam logic [2:0] PH_CNT_HI  = 3'd4;
    localparam logic [2:0] PH_CNT_LO  = 3'd5;
    localparam logic [2:0] PH_WORDS   = 3'd6;
    localparam logic [2:0] PH_CHARS   = 3'd7;

    localparam logic [15:0] TAG_CODE  = 16'hCADE;
    localparam logic [15:0] TAG_DATA  = 16'hDADA;
    localparam logic [15:0] TAG_LABEL = 16'hC3B7;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_tag, n_tag;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_high, n_high;
    logic        r_par, n_par;
    logic [15:0] full_cnt;
    logic        emit;
    t_item       item;

    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_high   = r_high;
        n_par    = r_par;
        emit     = 1'b0;
        full_cnt = {r_cnt[15:8], i_data_byte};
        item.rec_kind       = KIND_CODE;
        item.target_address = r_addr;
        item.payload        = 16'h0000;
        item.record_last    = (r_cnt == 16'd1);
        if (i_accept) begin
            case (r_phase)
                PH_TAG_HI: begin
                    n_tag   = {i_data_byte, 8'h00};
                    n_phase = PH_TAG_LO;
                end
                PH_TAG_LO: begin
                    n_tag   = {r_tag[15:8], i_data_byte};
                    n_phase = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                    n_addr  = {i_data_byte, 8'h00};
                    n_phase = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    n_addr  = {r_addr[15:8], i_data_byte};
                    n_phase = PH_CNT_HI;
                end
                PH_CNT_HI: begin
                    n_cnt   = {i_data_byte, 8'h00};
                    n_phase = PH_CNT_LO;
                end
                PH_CNT_LO: begin
                    n_cnt = full_cnt;
                    n_par = 1'b0;
                    if (r_tag == TAG_CODE || r_tag == TAG_DATA) begin
                        n_phase = (full_cnt == 16'd0) ? PH_TAG_HI : PH_WORDS;
                    end else if (r_tag == TAG_LABEL) begin
                        if (full_cnt == 16'd0) begin
                            emit             = 1'b1;
                            item.rec_kind    = KIND_EMPTY;
                            item.record_last = 1'b1;
                            n_phase          = PH_TAG_HI;
                        end else begin
                            n_phase = PH_CHARS;
                        end
                    end else begin
                        n_phase = PH_TAG_HI;
                    end
                end
                PH_WORDS: begin
                    if (!r_par) begin
                        n_high = i_data_byte;
                        n_par  = 1'b1;
                    end else begin
                        emit          = 1'b1;
                        item.rec_kind = (r_tag == TAG_CODE) ? KIND_CODE : KIND_DATA;
                        item.payload  = {r_high, i_data_byte};
                        n_addr        = r_addr + 16'd1;
                        n_cnt         = r_cnt - 16'd1;
                        n_par         = 1'b0;
                        if (r_cnt == 16'd1) begin
                            n_phase = PH_TAG_HI;
                        end
                    end
                end
                PH_CHARS: begin
                    emit          = 1'b1;
                    item.rec_kind = KIND_CHAR;
                    item.payload  = {8'h00, i_data_byte};
                    n_cnt         = r_cnt - 16'd1;
                    if (r_cnt == 16'd1) begin
                        n_phase = PH_TAG_HI;
                    end
                end
                default: begin
                    n_phase = PH_TAG_HI;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG_HI;
            r_tag   <= 16'h0000;
            r_addr  <= 16'h0000;
            r_cnt   <= 16'h0000;
            r_high  <= 8'h00;
            r_par   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_high  <= n_high;
            r_par   <= n_par;
        end
    end

    assign o_item_valid = emit;
    assign o_item       = item;

endmodule

@@ hdl/orsp_queue.sv @@
// Back part of the object record stream parser: a short register queue of result items.
// Depends on orsp_pkg; decouples the parser from the consumer of results.
module orsp_queue #(
    parameter int DEPTH = orsp_pkg::ORSP_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  orsp_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output orsp_pkg::t_item o_item
);
    import orsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hdl/object_record_stream_parser.sv @@
// Object record stream parser top level; depends on orsp_pkg, orsp_front and orsp_queue.
// The parser takes one byte of the object file in every cycle in which push is high and full is
// low. A byte that completes a result item writes it into a result queue of QUEUE_DEPTH entries
// as that byte is accepted, and reaches the result ports once the items ahead of it are popped.
// Full rises only when the queue holds QUEUE_DEPTH items that have not been popped; with pop
// held high the block sustains one byte per cycle indefinitely.
module object_record_stream_parser #(
    parameter int QUEUE_DEPTH = orsp_pkg::ORSP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_rec_kind,
    output logic [15:0] o_target_address,
    output logic [15:0] o_payload,
    output logic        o_record_last
);
    import orsp_pkg::*;

    logic  byte_accept;
    logic  item_valid;
    t_item front_item;
    t_item head_item;

    assign byte_accept = i_push && !o_full;

    orsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (byte_accept),
        .i_data_byte  (i_data_byte),
        .o_item_valid (item_valid),
        .o_item       (front_item)
    );

    orsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_valid),
        .i_item  (front_item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_item  (head_item)
    );

    assign o_rec_kind       = head_item.rec_kind;
    assign o_target_address = head_item.target_address;
    assign o_payload        = head_item.payload;
    assign o_record_last    = head_item.record_last;

endmodule

@@ hdl/orsp_checker.sv @@
// Port-level checker of the object record stream parser, bound to the top level.
// Depends on orsp_pkg and object_record_stream_parser_defines.svh.
`include "object_record_stream_parser_defines.svh"

module orsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_full,
    input logic        i_pop,
    input logic        o_empty,
    input logic [1:0]  o_rec_kind,
    input logic [15:0] o_target_address,
    input logic [15:0] o_payload,
    input logic        o_record_last
);
    import orsp_pkg::*;

    `ORSP_ASSERT_NEXT(a_head_holds, !o_empty && !i_pop,
        !o_empty && $stable(o_rec_kind) && $stable(o_target_address)
        && $stable(o_payload) && $stable(o_record_last),
        "Result changed while waiting to be popped.")
    `ORSP_ASSERT_SAME(a_empty_label, !o_empty && o_rec_kind == KIND_EMPTY,
        o_payload == 16'h0000 && o_record_last,
        "Empty label marker has a payload or is not last.")
    `ORSP_ASSERT_SAME(a_char_width, !o_empty && o_rec_kind == KIND_CHAR,
        o_payload[15:8] == 8'h00, "Label character wider than one byte.")
    `ORSP_ASSERT_RESET(a_reset_clear, !i_rst_n, o_empty && !o_full,
        "Result queue not empty after reset.")

endmodule

bind object_record_stream_parser orsp_checker u_orsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_full           (o_full),
    .i_pop            (i_pop),
    .o_empty          (o_empty),
    .o_rec_kind       (o_rec_kind),
    .o_target_address (o_target_address),
    .o_payload        (o_payload),
    .o_record_last    (o_record_last)
);

@@ bench/tb_top.sv @@
// Self-checking testbench for object_record_stream_parser, with its scoreboard class inside.
// It depends on orsp_pkg and the RTL. A byte-level record parser predicts every result item.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import orsp_pkg::*;

    localparam logic [15:0] TAG_CODE  = 16'hCADE;
    localparam logic [15:0] TAG_DATA  = 16'hDADA;
    localparam logic [15:0] TAG_LABEL = 16'hC3B7;
    localparam int          BYTE_GOAL = 1900;

    typedef enum logic [2:0] {
        P_TAG_HI, P_TAG_LO, P_ADDR_HI, P_ADDR_LO, P_CNT_HI, P_CNT_LO, P_WORDS, P_CHARS
    } parse_phase_e;

    class record_scoreboard;
        parse_phase_e phase;
        logic [15:0]  tag_word;
        logic [15:0]  rec_addr;
        logic [15:0]  remaining;
        logic [7:0]   high_byte;
        logic         low_pending;
        t_item        expected_items[$];
        int           errors;
        int           kind_seen[4];

        function new();
            phase       = P_TAG_HI;
            tag_word    = '0;
            rec_addr    = '0;
            remaining   = '0;
            high_byte   = '0;
            low_pending = 1'b0;
            errors      = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void expect_item(logic [1:0] kind, logic [15:0] addr, logic [15:0] pay,
                                  logic last);
            t_item it;
            it.rec_kind       = kind;
            it.target_address = addr;
            it.payload        = pay;
            it.record_last    = last;
            expected_items.push_back(it);
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                P_TAG_HI: begin
                    tag_word = {b, 8'h00};
                    phase    = P_TAG_LO;
                end
                P_TAG_LO: begin
                    tag_word[7:0] = b;
                    phase         = P_ADDR_HI;
                end
                P_ADDR_HI: begin
                    rec_addr = {b, 8'h00};
                    phase    = P_ADDR_LO;
                end
                P_ADDR_LO: begin
                    rec_addr[7:0] = b;
                    phase         = P_CNT_HI;
                end
                P_CNT_HI: begin
                    remaining = {b, 8'h00};
                    phase     = P_CNT_LO;
                end
                P_CNT_LO: begin
                    remaining[7:0] = b;
                    low_pending    = 1'b0;
                    if (tag_word == TAG_CODE || tag_word == TAG_DATA) begin
                        phase = (remaining == 16'd0) ? P_TAG_HI : P_WORDS;
                    end else if (tag_word == TAG_LABEL) begin
                        if (remaining == 16'd0) begin
                            expect_item(KIND_EMPTY, rec_addr, 16'h0000, 1'b1);
                            phase = P_TAG_HI;
                        end else begin
                            phase = P_CHARS;
                        end
                    end else begin
                        phase = P_TAG_HI;
                    end
                end
                P_WORDS: begin
                    if (!low_pending) begin
                        high_byte   = b;
                        low_pending = 1'b1;
                    end else begin
                        expect_item((tag_word == TAG_CODE) ? KIND_CODE : KIND_DATA, rec_addr,
                                    {high_byte, b}, remaining == 16'd1);
                        rec_addr    = rec_addr + 16'd1;
                        remaining   = remaining - 16'd1;
                        low_pending = 1'b0;
                        if (remaining == 16'd0) phase = P_TAG_HI;
                    end
                end
                default: begin
                    expect_item(KIND_CHAR, rec_addr, {8'h00, b}, remaining == 16'd1);
                    remaining = remaining - 16'd1;
                    if (remaining == 16'd0) phase = P_TAG_HI;
                end
            endcase
        endfunction

        function void check_result(t_item got);
            t_item want;
            if (expected_items.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: kind %0d address %h payload %h last %0d",
                         $time, got.rec_kind, got.target_address, got.payload, got.record_last);
                return;
            end
            want = expected_items.pop_front();
            kind_seen[got.rec_kind]++;
            if (got.rec_kind !== want.rec_kind) begin
                errors++;
                $display("%0t: rec_kind expected %0d actual %0d", $time, want.rec_kind,
                         got.rec_kind);
            end
            if (got.target_address !== want.target_address) begin
                errors++;
                $display("%0t: target_address expected %h actual %h", $time,
                         want.target_address, got.target_address);
            end
            if (got.payload !== want.payload) begin
                errors++;
                $display("%0t: payload expected %h actual %h", $time, want.payload,
                         got.payload);
            end
            if (got.record_last !== want.record_last) begin
                errors++;
                $display("%0t: record_last expected %0d actual %0d", $time, want.record_last,
                         got.record_last);
            end
        endfunction

        function int pending();
            return expected_items.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_push      = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_pop       = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [1:0]  o_rec_kind;
    logic [15:0] o_target_address;
    logic [15:0] o_payload;
    logic        o_record_last;

    record_scoreboard sb = new();
    int               bytes_sent = 0;
    bit               tx_burst   = 1'b0;
    bit               rx_burst   = 1'b0;

    object_record_stream_parser i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_data_byte      (i_data_byte),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_rec_kind       (o_rec_kind),
        .o_target_address (o_target_address),
        .o_payload        (o_payload),
        .o_record_last    (o_record_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                sb.check_result(t_item'({o_rec_kind, o_target_address, o_payload,
                                         o_record_last}));
            end
            if (i_push && !o_full) sb.note_byte(i_data_byte);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (bytes_sent % 128 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_full);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [15:0] tag, input logic [15:0] addr,
                               input logic [15:0] cnt);
        send_byte(tag[15:8]);
        send_byte(tag[7:0]);
        send_byte(addr[15:8]);
        send_byte(addr[7:0]);
        send_byte(cnt[15:8]);
        send_byte(cnt[7:0]);
    endtask

    task automatic send_random_record();
        int          sel;
        int          cnt;
        logic [15:0] tag;
        logic [15:0] addr;
        sel  = $urandom_range(0, 99);
        addr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                           : 16'($urandom);
        cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        if (sel < 36) begin
            tag = TAG_CODE;
        end else if (sel < 72) begin
            tag = TAG_DATA;
        end else if (sel < 90) begin
            tag = TAG_LABEL;
        end else begin
            // Unknown tags, some of them one byte away from a code tag.
            tag = (sel < 95) ? {8'hCA, 8'($urandom)} : 16'($urandom);
            if (tag == TAG_CODE || tag == TAG_DATA || tag == TAG_LABEL) tag = tag ^ 16'h0001;
            send_header(tag, addr, 16'($urandom));
            return;
        end
        send_header(tag, addr, 16'(cnt));
        repeat ((tag == TAG_LABEL) ? cnt : 2 * cnt) send_byte(8'($urandom));
    endtask

    initial begin
        int popped;
        bit held;
        popped = 0;
        held   = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            int gap;
            if (popped % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            // One long stall so that the result queue fills and the input backs up.
            if (popped == 100 && !held) begin
                held = 1'b1;
                i_pop <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
            popped++;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_header(TAG_CODE, 16'hFFFF, 16'd2);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(TAG_DATA, 16'h0000, 16'd0);
        send_header(TAG_LABEL, 16'hFFFF, 16'd0);
        send_header(16'hFFFF, 16'h0000, 16'd1);

        while (bytes_sent < BYTE_GOAL) send_random_record();

        // The stream ends in the middle of a word of a data record.
        send_header(TAG_DATA, 16'h0042, 16'd3);
        repeat (3) send_byte(8'($urandom));
        i_push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d bytes; checked %0d code writes, %0d data writes, %0d label chars",
                 bytes_sent, sb.kind_seen[KIND_CODE], sb.kind_seen[KIND_DATA],
                 sb.kind_seen[KIND_CHAR]);
        $display("and %0d empty labels, with random throttling and one long output stall.",
                 sb.kind_seen[KIND_EMPTY]);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding.", sb.pending());
        $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/orsp_pkg.sv
hdl/orsp_front.sv
hdl/orsp_queue.sv
hdl/object_record_stream_parser.sv
hdl/orsp_checker.sv
bench/tb_top.sv
